>>> src/ddr_pkg.sv
// shared types and constants for the delta / delta-delta regression unit
// item structs, datapath command struct, sequencer states, register indexes
`default_nettype none

package ddr_pkg;

	localparam int MAX_HALF_WINDOW = 8;
	localparam int SAMPLE_WIDTH    = 16;
	localparam int DELTA_WIDTH     = 16;
	localparam int TAP_W = (SAMPLE_WIDTH > DELTA_WIDTH) ? SAMPLE_WIDTH : DELTA_WIDTH;

	localparam int HW_W      = 4;
	localparam int NORM_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int FRAC_BITS = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_RECIP  = 1'b1;

	localparam logic [HW_W-1:0]   HALF_WINDOW_RST = 4'd2;
	localparam logic [NORM_W-1:0] NORM_RECIP_RST  = 16'd6554;

	// sample count of the running sequence, saturating
	localparam int SEEN_W = 6;
	localparam logic [SEEN_W-1:0] SEEN_CAP = '1;

	// signed width for index arithmetic in the sequencer
	localparam int IDX_W = SEEN_W + 2;
	localparam logic signed [IDX_W-1:0] IDX_ONE = IDX_W'(1);

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last;
	} in_item_t;

	typedef struct packed {
		logic signed [DELTA_WIDTH-1:0] delta;
		logic signed [DELTA_WIDTH-1:0] delta_delta;
		logic                          seq_end;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLAN,
		ST_DTAP,
		ST_DMUL,
		ST_DPUSH,
		ST_ETAP,
		ST_EMUL,
		ST_EOUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SRC_SAMPLE,
		SRC_DELTA,
		SRC_FIRST
	} tap_src_t;

	typedef struct packed {
		logic     shift_in;
		logic     acc_clr;
		logic     acc_en;
		logic     tap_neg;
		tap_src_t src;
		logic     mul_en;
		logic     cen_en;
		logic     push_delta;
		logic     set_first;
		logic     out_load;
		logic     seq_end;
	} dp_cmd_t;

endpackage

`default_nettype wire

>>> src/ddr_ctrl.sv
// sequencer for the regression unit: item intake, delta / output scheduling,
// end-of-sequence flush and tap address generation; uses ddr_pkg
`default_nettype none

module ddr_ctrl #(
	parameter int MAX_HALF_WINDOW = ddr_pkg::MAX_HALF_WINDOW
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic [ddr_pkg::HW_W-1:0]                    half_window,
	input  wire logic                                        cfg_clear,
	input  wire logic                                        feat_valid,
	input  wire logic                                        feat_last,
	output logic                                             feat_ready,
	input  wire logic                                        out_free,
	output ddr_pkg::dp_cmd_t                                 cmd,
	output logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]           tap_age,
	output logic [$clog2(MAX_HALF_WINDOW+1)-1:0]             tap_coef
);

	localparam int NW     = $clog2(MAX_HALF_WINDOW + 1);
	localparam int AGE_W  = $clog2(2 * MAX_HALF_WINDOW + 1);
	localparam int SEEN_W = ddr_pkg::SEEN_W;
	localparam int IDX_W  = ddr_pkg::IDX_W;

	ddr_pkg::ctrl_state_t state_q, state_nxt;

	logic [SEEN_W-1:0] seen_q;
	logic [SEEN_W-1:0] k_q;
	logic [SEEN_W-1:0] dnext_q;
	logic [SEEN_W-1:0] t_q;
	logic              last_q;
	logic              flush_q;
	logic [NW-1:0]     tap_n_q;
	logic              tap_ph_q;

	logic [NW-1:0] n_eff;
	logic          accept;
	logic          last_tap;
	logic          emit_phase;

	logic signed [IDX_W-1:0] k_s, n_s, dn_s, t_s, tn_s, m_s;
	logic signed [IDX_W-1:0] d_lim, e_lim, ctr, age_raw, age_c;
	logic signed [IDX_W-1:0] acc_k_s, init_d_s, init_t_s;
	logic [SEEN_W-1:0]       acc_k;
	logic                    want_delta, want_emit;
	logic                    plan_delta, plan_emit, plan_flush, plan_done;
	ddr_pkg::tap_src_t       src_c;

	// effective half window, clamped to 1..MAX_HALF_WINDOW
	always_comb begin
		if (half_window == '0) begin
			n_eff = NW'(1);
		end else if (int'(half_window) > MAX_HALF_WINDOW) begin
			n_eff = NW'(MAX_HALF_WINDOW);
		end else begin
			n_eff = NW'(half_window);
		end
	end

	assign accept = feat_valid && feat_ready;

	assign k_s  = $signed({2'b00, k_q});
	assign dn_s = $signed({2'b00, dnext_q});
	assign t_s  = $signed({2'b00, t_q});
	assign n_s  = $signed({{(IDX_W-NW){1'b0}}, n_eff});
	assign tn_s = $signed({{(IDX_W-NW){1'b0}}, tap_n_q});
	assign m_s  = dn_s - ddr_pkg::IDX_ONE;

	// newest sample index of the item being taken in
	assign acc_k    = (seen_q == ddr_pkg::SEEN_CAP) ? (seen_q - SEEN_W'(1)) : seen_q;
	assign acc_k_s  = $signed({2'b00, acc_k});
	assign init_d_s = (acc_k_s - n_s < 0) ? '0 : acc_k_s - n_s;
	assign init_t_s = (acc_k_s - n_s - n_s < 0) ? '0 : acc_k_s - n_s - n_s;

	// how far deltas and outputs may run: steady lags of N and 2N, or the flush limits
	always_comb begin
		if (flush_q) begin
			d_lim = (t_s + n_s < k_s) ? t_s + n_s : k_s;
			e_lim = k_s;
		end else begin
			d_lim = k_s - n_s;
			e_lim = k_s - n_s - n_s;
		end
	end

	assign want_delta = dn_s <= d_lim;
	assign want_emit  = t_s <= e_lim;
	assign plan_delta = want_delta;
	assign plan_emit  = !want_delta && want_emit;
	assign plan_flush = !want_delta && !want_emit && last_q && !flush_q;
	assign plan_done  = !want_delta && !want_emit && !(last_q && !flush_q);

	assign last_tap   = tap_ph_q && (tap_n_q == n_eff);
	assign emit_phase = (state_q == ddr_pkg::ST_ETAP) || (state_q == ddr_pkg::ST_EMUL);

	// tap address: center age plus or minus n, clamped to the sequence ends
	always_comb begin
		ctr = emit_phase ? (m_s - t_s) : (k_s - dn_s);
		if (state_q == ddr_pkg::ST_EMUL) begin
			age_raw = ctr;
		end else if (tap_ph_q) begin
			age_raw = ctr + tn_s;
		end else begin
			age_raw = ctr - tn_s;
		end
		age_c = age_raw;
		src_c = emit_phase ? ddr_pkg::SRC_DELTA : ddr_pkg::SRC_SAMPLE;
		if (age_raw < 0) begin
			age_c = '0;
		end else if (emit_phase) begin
			// older than the first delta of the sequence
			if (age_raw > m_s) begin
				src_c = ddr_pkg::SRC_FIRST;
			end
		end else if (age_raw > k_s) begin
			age_c = k_s;
		end
	end

	assign tap_age  = age_c[AGE_W-1:0];
	assign tap_coef = tap_n_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ddr_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = ddr_pkg::ST_PLAN;
				end
			end
			ddr_pkg::ST_PLAN: begin
				if (plan_delta) begin
					state_nxt = ddr_pkg::ST_DTAP;
				end else if (plan_emit) begin
					state_nxt = ddr_pkg::ST_ETAP;
				end else if (plan_done) begin
					state_nxt = ddr_pkg::ST_IDLE;
				end
			end
			ddr_pkg::ST_DTAP: begin
				if (last_tap) begin
					state_nxt = ddr_pkg::ST_DMUL;
				end
			end
			ddr_pkg::ST_DMUL:  state_nxt = ddr_pkg::ST_DPUSH;
			ddr_pkg::ST_DPUSH: state_nxt = ddr_pkg::ST_PLAN;
			ddr_pkg::ST_ETAP: begin
				if (last_tap) begin
					state_nxt = ddr_pkg::ST_EMUL;
				end
			end
			ddr_pkg::ST_EMUL: state_nxt = ddr_pkg::ST_EOUT;
			ddr_pkg::ST_EOUT: begin
				if (out_free) begin
					state_nxt = ddr_pkg::ST_PLAN;
				end
			end
			default: state_nxt = ddr_pkg::ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd        = '0;
		cmd.src    = src_c;
		feat_ready = 1'b0;
		case (state_q)
			ddr_pkg::ST_IDLE: begin
				feat_ready   = 1'b1;
				cmd.shift_in = accept;
			end
			ddr_pkg::ST_PLAN: begin
				cmd.acc_clr = plan_delta || plan_emit;
			end
			ddr_pkg::ST_DTAP, ddr_pkg::ST_ETAP: begin
				cmd.acc_en  = 1'b1;
				cmd.tap_neg = tap_ph_q;
			end
			ddr_pkg::ST_DMUL: begin
				cmd.mul_en = 1'b1;
			end
			ddr_pkg::ST_DPUSH: begin
				cmd.push_delta = 1'b1;
				cmd.set_first  = (dnext_q == '0);
			end
			ddr_pkg::ST_EMUL: begin
				cmd.mul_en = 1'b1;
				cmd.cen_en = 1'b1;
			end
			ddr_pkg::ST_EOUT: begin
				cmd.out_load = out_free;
				cmd.seq_end  = flush_q && (t_q == k_q);
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ddr_pkg::ST_IDLE;
			seen_q   <= '0;
			k_q      <= '0;
			dnext_q  <= '0;
			t_q      <= '0;
			last_q   <= 1'b0;
			flush_q  <= 1'b0;
			tap_n_q  <= '0;
			tap_ph_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ddr_pkg::ST_IDLE: begin
					if (accept) begin
						k_q     <= acc_k;
						last_q  <= feat_last;
						flush_q <= 1'b0;
						dnext_q <= init_d_s[SEEN_W-1:0];
						t_q     <= init_t_s[SEEN_W-1:0];
						if (seen_q != ddr_pkg::SEEN_CAP) begin
							seen_q <= seen_q + SEEN_W'(1);
						end
					end
				end
				ddr_pkg::ST_PLAN: begin
					if (plan_delta || plan_emit) begin
						tap_n_q  <= NW'(1);
						tap_ph_q <= 1'b0;
					end
					if (plan_flush) begin
						flush_q <= 1'b1;
					end
					// sequence flushed: next item opens a new one
					if (plan_done && flush_q) begin
						seen_q <= '0;
					end
				end
				ddr_pkg::ST_DTAP, ddr_pkg::ST_ETAP: begin
					tap_ph_q <= !tap_ph_q;
					if (tap_ph_q) begin
						tap_n_q <= tap_n_q + NW'(1);
					end
				end
				ddr_pkg::ST_DPUSH: begin
					dnext_q <= dnext_q + SEEN_W'(1);
				end
				ddr_pkg::ST_EOUT: begin
					if (out_free) begin
						t_q <= t_q + SEEN_W'(1);
					end
				end
				default: begin
				end
			endcase
			if (cfg_clear) begin
				seen_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/ddr_datapath.sv
// datapath of the regression unit: sample and delta windows, tap
// multiply-accumulate, Q16 scaling with rounding and saturation, result register
`default_nettype none

module ddr_datapath #(
	parameter int MAX_HALF_WINDOW = ddr_pkg::MAX_HALF_WINDOW
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire ddr_pkg::dp_cmd_t                      cmd,
	input  wire logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0] tap_age,
	input  wire logic [$clog2(MAX_HALF_WINDOW+1)-1:0]  tap_coef,
	input  wire logic [ddr_pkg::NORM_W-1:0]            norm_recip,
	input  wire logic signed [ddr_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic                                       out_free,
	output logic                                       res_valid,
	input  wire logic                                  res_ready,
	output ddr_pkg::out_item_t                         res
);

	localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 1;
	localparam int NW     = $clog2(MAX_HALF_WINDOW + 1);
	localparam int SW     = ddr_pkg::SAMPLE_WIDTH;
	localparam int DW     = ddr_pkg::DELTA_WIDTH;
	localparam int TAP_W  = ddr_pkg::TAP_W;
	localparam int TRI    = MAX_HALF_WINDOW * (MAX_HALF_WINDOW + 1) / 2;
	localparam int ACC_W  = TAP_W + 1 + $clog2(TRI + 1);
	localparam int PROD_W = ACC_W + ddr_pkg::NORM_W + 1;
	localparam int FB     = ddr_pkg::FRAC_BITS;
	localparam int Q_W    = PROD_W + 1 - FB;

	localparam logic signed [PROD_W:0] RND_HALF =
		{{(PROD_W-FB+1){1'b0}}, 1'b1, {(FB-1){1'b0}}};
	localparam logic signed [Q_W-1:0] Q_MAX = {{(Q_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {{(Q_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

	logic signed [SW-1:0]     x_win_q [DEPTH];
	logic signed [DW-1:0]     d_win_q [DEPTH];
	logic signed [DW-1:0]     first_q;
	logic signed [DW-1:0]     dcen_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	ddr_pkg::out_item_t       res_q;
	logic                     res_valid_q;

	logic signed [TAP_W-1:0]    tap_val;
	logic signed [TAP_W+NW:0]   term;
	logic signed [ACC_W-1:0]    acc_nxt;
	logic signed [PROD_W:0]     rnd;
	logic signed [Q_W-1:0]      q;
	logic signed [DW-1:0]       scaled;

	always_comb begin
		case (cmd.src)
			ddr_pkg::SRC_SAMPLE: tap_val = TAP_W'(x_win_q[tap_age]);
			ddr_pkg::SRC_DELTA:  tap_val = TAP_W'(d_win_q[tap_age]);
			ddr_pkg::SRC_FIRST:  tap_val = TAP_W'(first_q);
			default:             tap_val = '0;
		endcase
	end

	// one weighted tap per cycle: +n for the newer side, -n for the older
	assign term    = tap_val * $signed({1'b0, tap_coef});
	assign acc_nxt = cmd.tap_neg ? (acc_q - ACC_W'(term)) : (acc_q + ACC_W'(term));

	// round half up is an arithmetic shift after adding one half
	assign rnd = $signed({prod_q[PROD_W-1], prod_q}) + RND_HALF;
	assign q   = rnd[PROD_W:FB];

	always_comb begin
		if (q > Q_MAX) begin
			scaled = {1'b0, {(DW-1){1'b1}}};
		end else if (q < Q_MIN) begin
			scaled = {1'b1, {(DW-1){1'b0}}};
		end else begin
			scaled = q[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_in) begin
			x_win_q[0] <= sample;
			for (int i = 1; i < DEPTH; i++) begin
				x_win_q[i] <= x_win_q[i-1];
			end
		end
		if (cmd.push_delta) begin
			d_win_q[0] <= scaled;
			for (int i = 1; i < DEPTH; i++) begin
				d_win_q[i] <= d_win_q[i-1];
			end
			if (cmd.set_first) begin
				first_q <= scaled;
			end
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_nxt;
		end
		if (cmd.mul_en) begin
			prod_q <= acc_q * $signed({1'b0, norm_recip});
		end
		if (cmd.cen_en) begin
			dcen_q <= tap_val[DW-1:0];
		end
		if (cmd.out_load) begin
			res_q.delta       <= dcen_q;
			res_q.delta_delta <= scaled;
			res_q.seq_end     <= cmd.seq_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

>>> src/delta_delta_regression_unit.sv
// top level of the delta / delta-delta regression unit: config registers,
// sequencer (ddr_ctrl) and datapath (ddr_datapath); uses ddr_pkg
//
//  channel   handshake             payload                 dir
//  feat      feat_valid/feat_ready ddr_pkg::in_item_t      in
//  res       res_valid/res_ready   ddr_pkg::out_item_t     out
//  cfg       cfg_we                cfg_index, cfg_data     in
//
// steady state: one delta and one output per item, N the effective half window; one shared
//   multiply-accumulate visits one window entry per cycle, 2N taps per delta
//   and 2N per delta-delta
// the last item of a sequence also runs the flush: the remaining deltas and
//   the remaining outputs of the sequence
// arst_n resets control state and the config registers to their defaults; window
//   contents are only read after the running sequence has written them
// a result waits in the output register; the next one waits in the sequencer
//   while res_ready is low
`default_nettype none

module delta_delta_regression_unit #(
	parameter int MAX_HALF_WINDOW = ddr_pkg::MAX_HALF_WINDOW
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              feat_valid,
	output logic                                   feat_ready,
	input  wire ddr_pkg::in_item_t                 feat,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output ddr_pkg::out_item_t                     res,
	input  wire logic                              cfg_we,
	input  wire logic [ddr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ddr_pkg::CFG_W-1:0]         cfg_data
);

	localparam int NW    = $clog2(MAX_HALF_WINDOW + 1);
	localparam int AGE_W = $clog2(2 * MAX_HALF_WINDOW + 1);

	logic [ddr_pkg::HW_W-1:0]   half_window_q;
	logic [ddr_pkg::NORM_W-1:0] norm_recip_q;
	logic                       cfg_clear;
	logic                       out_free;
	ddr_pkg::dp_cmd_t           cmd;
	logic [AGE_W-1:0]           tap_age;
	logic [NW-1:0]              tap_coef;

	// a new half window starts a fresh sequence
	assign cfg_clear = cfg_we && (cfg_index == ddr_pkg::REG_HALF_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q <= ddr_pkg::HALF_WINDOW_RST;
			norm_recip_q  <= ddr_pkg::NORM_RECIP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ddr_pkg::REG_HALF_WINDOW: half_window_q <= cfg_data[ddr_pkg::HW_W-1:0];
				ddr_pkg::REG_NORM_RECIP:  norm_recip_q  <= cfg_data[ddr_pkg::NORM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ddr_ctrl #(
		.MAX_HALF_WINDOW(MAX_HALF_WINDOW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.half_window(half_window_q),
		.cfg_clear  (cfg_clear),
		.feat_valid (feat_valid),
		.feat_last  (feat.last),
		.feat_ready (feat_ready),
		.out_free   (out_free),
		.cmd        (cmd),
		.tap_age    (tap_age),
		.tap_coef   (tap_coef)
	);

	ddr_datapath #(
		.MAX_HALF_WINDOW(MAX_HALF_WINDOW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.tap_age   (tap_age),
		.tap_coef  (tap_coef),
		.norm_recip(norm_recip_q),
		.sample    (feat.sample),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

`default_nettype wire

>>> src/ddr_checker.sv
// port-level checks for delta_delta_regression_unit, bound to the top level
// uses ddr_pkg for the result item type
`default_nettype none

module ddr_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               feat_valid,
	input wire logic               feat_ready,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire ddr_pkg::out_item_t res
);

	// a stalled result item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	// the unit works on one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		feat_valid && feat_ready |=> !feat_ready)
		else $error("input taken on two consecutive cycles");

	// a new result only comes out of a busy sequencer
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(feat_ready))
		else $error("result appeared while idle");

endmodule

bind delta_delta_regression_unit ddr_checker u_ddr_checker (.*);

`default_nettype wire

>>> tb/sv/delta_feature_monitor.sv
// watches the feature, result and register ports of delta_delta_regression_unit,
// predicts every result item and compares it field by field
// depends on ddr_pkg for the item structs, widths and register indexes
module delta_feature_monitor
	import ddr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 feat_valid,
	input  wire logic                 feat_ready,
	input  wire in_item_t             feat,
	input  wire logic                 res_valid,
	input  wire logic                 res_ready,
	input  wire out_item_t            res,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output int                        errors,
	output int                        pending
);

	localparam int DEPTH     = 2 * MAX_HALF_WINDOW + 1;
	localparam int COUNT_CAP = int'(SEEN_CAP);

	longint            sample_hist [DEPTH];
	longint            delta_hist [DEPTH];
	longint            first_delta;
	int                seq_count;
	logic [HW_W-1:0]   half_window;
	logic [NORM_W-1:0] norm_recip;
	out_item_t         feature_results_q [$];
	out_item_t         want;
	int                fail_cnt;

	function automatic int window_taps();
		if (half_window == '0)
			return 1;
		if (half_window > MAX_HALF_WINDOW)
			return MAX_HALF_WINDOW;
		return int'(half_window);
	endfunction

	function automatic void clear_sequence();
		foreach (sample_hist[i])
			sample_hist[i] = 0;
		foreach (delta_hist[i])
			delta_hist[i] = 0;
		seq_count = 0;
		first_delta = 0;
	endfunction

	// q16 scaling, round half up (floor of the biased product), then saturate
	function automatic longint scale_q16(longint tap_sum);
		longint nr;
		longint q;
		nr = norm_recip;
		q = (tap_sum * nr + 32768) >>> 16;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q;
	endfunction

	// age 0 is the newest sample, the first sample of the sequence has age newest
	function automatic longint sample_at(int age, int newest);
		if (age < 0)
			age = 0;
		if (age > newest)
			age = newest;
		if (age > DEPTH - 1)
			age = DEPTH - 1;
		return sample_hist[age];
	endfunction

	function automatic longint delta_at(int age, int newest);
		if (age < 0)
			age = 0;
		if (age > newest)
			return first_delta;
		if (age > DEPTH - 1)
			age = DEPTH - 1;
		return delta_hist[age];
	endfunction

	function automatic void compute_delta(int idx, int newest, int taps);
		longint acc;
		longint d;
		int     n;
		acc = 0;
		for (n = 1; n <= taps; n++)
			acc += n * (sample_at(newest - idx - n, newest) -
				sample_at(newest - idx + n, newest));
		d = scale_q16(acc);
		for (n = DEPTH - 1; n > 0; n--)
			delta_hist[n] = delta_hist[n - 1];
		delta_hist[0] = d;
		if (idx == 0)
			first_delta = d;
	endfunction

	function automatic void queue_result(int t, int newest_d, int taps, logic is_end);
		longint    acc;
		out_item_t r;
		int        n;
		acc = 0;
		for (n = 1; n <= taps; n++)
			acc += n * (delta_at(newest_d - t - n, newest_d) -
				delta_at(newest_d - t + n, newest_d));
		r.delta       = 16'(delta_at(newest_d - t, newest_d));
		r.delta_delta = 16'(scale_q16(acc));
		r.seq_end     = is_end;
		feature_results_q.push_back(r);
	endfunction

	function automatic void absorb_sample(in_item_t it);
		int taps;
		int newest;
		int first_out;
		int next_d;
		int newest_d;
		int lim;
		int i;
		taps = window_taps();
		for (i = DEPTH - 1; i > 0; i--)
			sample_hist[i] = sample_hist[i - 1];
		sample_hist[0] = $signed(it.sample);
		if (seq_count < COUNT_CAP)
			seq_count++;
		newest = seq_count - 1;
		if (newest >= taps)
			compute_delta(newest - taps, newest, taps);
		if (newest >= 2 * taps)
			queue_result(newest - 2 * taps, newest - taps, taps, 1'b0);
		if (it.last) begin
			// flush: finish the missing deltas lazily, emit every pending output
			first_out = newest - 2 * taps + 1;
			next_d = newest - taps + 1;
			if (first_out < 0)
				first_out = 0;
			if (next_d < 0)
				next_d = 0;
			newest_d = next_d - 1;
			for (i = first_out; i <= newest; i++) begin
				lim = (i + taps > newest) ? newest : i + taps;
				while (next_d <= lim) begin
					compute_delta(next_d, newest, taps);
					newest_d = next_d;
					next_d++;
				end
				queue_result(i, newest_d, taps, i == newest);
			end
			clear_sequence();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window = HALF_WINDOW_RST;
			norm_recip = NORM_RECIP_RST;
			clear_sequence();
			feature_results_q.delete();
			fail_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_HALF_WINDOW) begin
					half_window = cfg_data[HW_W-1:0];
					clear_sequence();
				end else if (cfg_index == REG_NORM_RECIP) begin
					norm_recip = cfg_data[NORM_W-1:0];
				end
			end
			if (res_valid && res_ready) begin
				if (feature_results_q.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected result: expected none, actual %0d %0d %0b",
						$time, res.delta, res.delta_delta, res.seq_end);
				end else begin
					want = feature_results_q.pop_front();
					if (res.delta !== want.delta) begin
						fail_cnt++;
						$display("%0t: delta: expected %0d, actual %0d",
							$time, want.delta, res.delta);
					end
					if (res.delta_delta !== want.delta_delta) begin
						fail_cnt++;
						$display("%0t: delta_delta: expected %0d, actual %0d",
							$time, want.delta_delta, res.delta_delta);
					end
					if (res.seq_end !== want.seq_end) begin
						fail_cnt++;
						$display("%0t: seq_end: expected %0b, actual %0b",
							$time, want.seq_end, res.seq_end);
					end
				end
			end
			if (feat_valid && feat_ready)
				absorb_sample(feat);
			errors <= fail_cnt;
			pending <= feature_results_q.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// stimulus and verdict for delta_delta_regression_unit: sequences of samples,
// register settings and random back-pressure; checking sits in delta_feature_monitor
// depends on ddr_pkg, delta_delta_regression_unit and delta_feature_monitor
module testbench;
	import ddr_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 120;
	localparam int IDLE_PCT      = 36;

	localparam int SHAPE_NOISE   = 0;
	localparam int SHAPE_EXTREME = 1;
	localparam int SHAPE_SMOOTH  = 2;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 feat_valid = 1'b0;
	logic                 feat_ready;
	in_item_t             feat       = '0;
	logic                 res_valid;
	logic                 res_ready  = 1'b0;
	out_item_t            res;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = REG_HALF_WINDOW;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 no_stall   = 1'b0;
	int                   errors;
	int                   pending;
	int                   cycles     = 0;

	always #1 clk = ~clk;

	delta_delta_regression_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.feat_valid (feat_valid),
		.feat_ready (feat_ready),
		.feat       (feat),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	delta_feature_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.feat_valid (feat_valid),
		.feat_ready (feat_ready),
		.feat       (feat),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending)
	);

	always @(posedge clk) begin
		res_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// normalizer that matches the effective half window
	function automatic logic [NORM_W-1:0] matched_norm(int hw);
		int n;
		int sq;
		n = (hw < 1) ? 1 : (hw > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : hw;
		sq = n * (n + 1) * (2 * n + 1) / 6;
		return NORM_W'((65536 + sq) / (2 * sq));
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(int shape,
		logic signed [SAMPLE_WIDTH-1:0] prev);
		int v;
		case (shape)
			SHAPE_EXTREME: begin
				v = $urandom_range(1) ? 32767 - int'($urandom_range(3))
					: -32768 + int'($urandom_range(3));
			end
			SHAPE_SMOOTH: begin
				v = int'(prev) + int'($urandom_range(1023)) - 512;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
			end
			default: begin
				v = $urandom;
			end
		endcase
		return SAMPLE_WIDTH'(v);
	endfunction

	task automatic send_item(input logic signed [SAMPLE_WIDTH-1:0] s, input logic lst);
		while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
			feat_valid <= 1'b0;
			@(posedge clk);
		end
		feat_valid <= 1'b1;
		feat <= '{sample: s, last: lst};
		@(posedge clk);
		while (!feat_ready)
			@(posedge clk);
	endtask

	// hold the sender until every predicted result item has come back
	task automatic drain();
		feat_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [HW_W-1:0] hw, input logic [NORM_W-1:0] nr);
		cfg_we <= 1'b1;
		cfg_index <= REG_HALF_WINDOW;
		cfg_data <= CFG_W'(hw);
		@(posedge clk);
		cfg_index <= REG_NORM_RECIP;
		cfg_data <= CFG_W'(nr);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sequence(int len, bit with_last, int shape, int hold_at);
		logic signed [SAMPLE_WIDTH-1:0] s;
		int i;
		s = $urandom;
		for (i = 0; i < len; i++) begin
			if (i == hold_at)
				drain();
			s = pick_sample(shape, s);
			send_item(s, with_last && i == len - 1);
		end
	endtask

	initial begin
		int ph;
		int budget;
		int len;
		int hw;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, full-scale swings
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh8000, 1'b0);
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh8000, 1'b0);
		send_item(16'sh0000, 1'b0);
		send_item(16'sh0001, 1'b0);
		send_item(16'shffff, 1'b1);
		// one-sample sequence, then one shorter than the window
		send_item(16'sh1234, 1'b1);
		send_item(-16'sd100, 1'b0);
		send_item(16'sd200, 1'b0);
		send_item(-16'sd300, 1'b1);
		// open sequence dropped by the half window write below
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh4000, 1'b0);
		send_item(16'sh8000, 1'b0);
		settle();
		// zero half window acts as one, full gain saturates
		set_config(4'd0, 16'hffff);
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh8000, 1'b0);
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh8000, 1'b1);
		settle();
		// oversized half window clamps to the maximum, zero gain
		set_config(4'hf, 16'd0);
		send_item(16'sh5555, 1'b0);
		send_item(16'shaaaa, 1'b1);
		settle();
		set_config(4'(MAX_HALF_WINDOW), matched_norm(MAX_HALF_WINDOW));
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh8000, 1'b0);
		send_item(16'sh7fff, 1'b1);

		for (ph = 0; ph < 4; ph++) begin
			settle();
			hw = $urandom_range(15);
			set_config(4'(hw), ($urandom_range(4) == 0) ? NORM_W'($urandom) : matched_norm(hw));
			no_stall <= (ph == 2);
			budget = 4;
			if (ph == 1) begin
				// long enough for the sample count to saturate
				send_sequence(66, 1'b1, SHAPE_SMOOTH, -1);
				budget = 0;
			end
			while (budget > 0) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 8);
				send_sequence(len, 1'b1, $urandom_range(SHAPE_SMOOTH),
					(ph == 3) ? len / 2 : -1);
				budget -= len;
			end
			if ($urandom_range(1))
				send_sequence($urandom_range(1, 3), 1'b0, $urandom_range(SHAPE_SMOOTH), -1);
		end

		settle();
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
